### rtl/orf_pkg.sv
`default_nettype none
package orf_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int FRAC_BITS      = 8;
    localparam int REPEL_GAIN     = 80;
    localparam int REPEL_REACH    = 25;

    localparam int CFG_W      = 9;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int SHADE_W    = 20;
    localparam int PART_W     = 17;
    localparam int GROUP_W    = 19;
    localparam int WIN        = 9;
    localparam int HALF_WIN   = 4;
    localparam int LINES      = 8;
    localparam int ROW_OUT_W  = 8;
    localparam int COL_OUT_W  = 8;

    localparam logic [SHADE_W-1:0] SHADE_LIMIT = SHADE_W'(1 << (SHADE_W - 1));

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } orf_reg_t;

    typedef struct packed {
        logic             shift;
        logic             advance;
        logic [WIN-1:0]   row_ok;
        logic             col_ok;
    } orf_cell_ctrl_t;

    // round((GAIN << FRAC_BITS) / d), GAIN << FRAC_BITS at d = 0; zero at and past reach
    function automatic logic [PART_W-1:0] kernel_weight(input int d);
        logic [PART_W-1:0] w;
        case (d)
            0:       w = PART_W'(REPEL_GAIN << FRAC_BITS);
            1:       w = PART_W'(20480);
            2:       w = PART_W'(10240);
            4:       w = PART_W'(5120);
            5:       w = PART_W'(4096);
            8:       w = PART_W'(2560);
            9:       w = PART_W'(2276);
            10:      w = PART_W'(2048);
            13:      w = PART_W'(1575);
            16:      w = PART_W'(1280);
            17:      w = PART_W'(1205);
            18:      w = PART_W'(1138);
            20:      w = PART_W'(1024);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### rtl/orf_if.sv
`default_nettype none
interface orf_in_if;
    logic valid;
    logic ready;
    logic obstacle;
    logic frame_start;

    modport source (output valid, output obstacle, output frame_start, input ready);
    modport sink (input valid, input obstacle, input frame_start, output ready);
endinterface

interface orf_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] shade_value;
    logic [7:0]         cell_row;
    logic [7:0]         cell_column;
    logic               frame_last;

    modport source (output valid, output shade_value, output cell_row, output cell_column,
                    output frame_last, input ready);
    modport sink (input valid, input shade_value, input cell_row, input cell_column,
                  input frame_last, output ready);
endinterface
`default_nettype wire

### rtl/orf_line_store.sv
`default_nettype none
module orf_line_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 8
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // same-column write in flight is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data <= wr_data;
            end
            else
            begin
                rd_data <= mem[rd_addr];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/orf_cell.sv
`default_nettype none
module orf_cell #(
    parameter int DC = 0
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire orf_pkg::orf_cell_ctrl_t ctrl,
    input  wire logic [orf_pkg::WIN-1:0] col_in,
    output logic      [orf_pkg::WIN-1:0] col_out,
    output logic   [orf_pkg::PART_W-1:0] partial
);
    import orf_pkg::*;

    logic [WIN-1:0]    col_reg;
    logic [PART_W-1:0] partial_reg;
    logic [PART_W-1:0] partial_next;

    always_comb
    begin
        partial_next = '0;
        for (int i = 0; i < WIN; i++)
        begin
            if (col_reg[i] && ctrl.row_ok[i] && ctrl.col_ok)
            begin
                partial_next = partial_next +
                    kernel_weight((i - HALF_WIN) * (i - HALF_WIN) + DC * DC);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            partial_reg <= partial_next;
        end
    end

    assign col_out = col_reg;
    assign partial = partial_reg;

endmodule
`default_nettype wire

### rtl/obstacle_repulsion_field_unit.sv
// Obstacle repulsion field.
// item_in carries one bitmap cell per item in raster order (obstacle, frame_start);
// result_out gives the Q.8 repulsion value with the cell's row, column and a
// frame_last flag. Both channels are valid/ready.
// A frame is W*H + 4W + 4 items: the result for a cell leaves once the cell
// 4 rows and 4 columns further on is in, so the first 4W+4 items give none and
// the tail items only push the window on.
// One item per cycle while result_out does not stall. An accepted item passes
// the line store read, the 9x9 window in a chain of nine column cells,
// per-column partial sums, a two-level add and the final negate, each
// registered, before its result sits in the output register.
// When result_out stalls, the whole pipe holds and item_in.ready drops; the
// output register keeps its item until taken.
// grid_width and grid_height lie at 0x0 and 0x4 on the APB port; write them
// between frames. item_in.ready is low for one cycle after a write.
// Reset clears counters, the window and the pipe valids; the line store is
// not cleared, off-grid cells are masked instead.
`default_nettype none
module obstacle_repulsion_field_unit #(
    parameter int MAX_WIDTH  = orf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = orf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    orf_in_if.sink                              item_in,
    orf_out_if.source                           result_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [orf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [orf_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [orf_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import orf_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 9);
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 4 * MAX_WIDTH + 5);

    // configuration
    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic             cfg_hold_reg;
    logic             cfg_wr;
    logic [DW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    orf_reg_t         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = orf_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_W'(256);
            height_cfg_reg <= CFG_W'(256);
            cfg_hold_reg   <= 1'b0;
        end
        else
        begin
            cfg_hold_reg <= cfg_wr;
            if (cfg_wr)
            begin
                unique case (cfg_sel)
                    REG_GRID_WIDTH:  width_cfg_reg  <= pwdata[CFG_W-1:0];
                    REG_GRID_HEIGHT: height_cfg_reg <= pwdata[CFG_W-1:0];
                    default:         width_cfg_reg  <= width_cfg_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(width_cfg_reg);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(height_cfg_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            w_eff = DW'(1);
        end
        else if (32'(width_cfg_reg) > MAX_WIDTH)
        begin
            w_eff = DW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = DW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(height_cfg_reg);
        end
    end

    // pipe control
    logic adv;
    logic accept;
    logic out_valid_reg;

    assign adv           = !out_valid_reg || result_out.ready;
    assign item_in.ready = adv && !cfg_hold_reg;
    assign accept        = item_in.valid && item_in.ready;

    // input position
    logic [CW-1:0] col_reg,  col_next,  col_e;
    logic [RW-1:0] row_reg,  row_next,  row_e;
    logic [PW-1:0] pos_reg,  pos_next,  pos_e;
    logic [PW-1:0] lag_reg,  last_reg;
    logic          restart;

    always_comb
    begin
        restart = item_in.frame_start || (32'(col_reg) >= 32'(w_eff)) || (pos_reg > last_reg);
        col_e   = restart ? '0 : col_reg;
        row_e   = restart ? '0 : row_reg;
        pos_e   = restart ? '0 : pos_reg;
        if (pos_e == last_reg)
        begin
            col_next = '0;
            row_next = '0;
            pos_next = '0;
        end
        else if (32'(col_e) + 1 >= 32'(w_eff))
        begin
            col_next = '0;
            row_next = row_e + RW'(1);
            pos_next = pos_e + PW'(1);
        end
        else
        begin
            col_next = col_e + CW'(1);
            row_next = row_e;
            pos_next = pos_e + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            pos_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            pos_reg <= pos_next;
        end
        else
        begin
            pos_reg <= PW'(32'(row_reg) * 32'(w_eff) + 32'(col_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        lag_reg  <= PW'(4 * 32'(w_eff) + 4);
        last_reg <= PW'(32'(w_eff) * 32'(h_eff) + 4 * 32'(w_eff) + 3);
    end

    // stage 1: line store access
    logic             s1_valid_reg;
    logic             s1_bit_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [RW-1:0]    s1_row_reg;
    logic             s1_out_en_reg;
    logic             s1_last_reg;
    logic [LINES-1:0] s1_word;
    logic             ls_wr;

    assign ls_wr = s1_valid_reg && adv;

    orf_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (LINES)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ls_wr),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_word[LINES-2:0], s1_bit_reg}),
        .rd_en   (accept),
        .rd_addr (col_e),
        .rd_data (s1_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bit_reg    <= item_in.obstacle;
            s1_col_reg    <= col_e;
            s1_row_reg    <= row_e;
            s1_out_en_reg <= (pos_e >= lag_reg);
            s1_last_reg   <= (pos_e == last_reg);
        end
    end

    // result cell is 4W+4 items back
    logic signed [CW+1:0] cs;
    logic signed [RW:0]   rs;
    logic [WIN-1:0]       new_col;

    always_comb
    begin
        cs = $signed((CW+2)'(s1_col_reg)) - $signed((CW+2)'(HALF_WIN));
        rs = $signed((RW+1)'(s1_row_reg)) - $signed((RW+1)'(HALF_WIN));
        for (int i = 0; i < HALF_WIN; i++)
        begin
            if (cs < 0)
            begin
                cs = cs + $signed((CW+2)'(w_eff));
                rs = rs - $signed((RW+1)'(1));
            end
        end
        new_col[WIN-1] = s1_bit_reg;
        for (int k = 0; k < LINES; k++)
        begin
            new_col[LINES-1-k] = s1_word[k];
        end
    end

    // stage 2: window
    logic          s2_valid_reg;
    logic [RW-1:0] s2_r_reg;
    logic [CW-1:0] s2_c_reg;
    logic          s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg && s1_out_en_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_r_reg    <= rs[RW-1:0];
            s2_c_reg    <= cs[CW-1:0];
            s2_last_reg <= s1_last_reg;
        end
    end

    logic [WIN-1:0]    row_ok;
    orf_cell_ctrl_t    cell_ctrl [WIN];
    logic [WIN-1:0]    chain [WIN];
    logic [PART_W-1:0] part [WIN];

    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            row_ok[i] = (int'(s2_r_reg) + i - HALF_WIN >= 0) &&
                        (int'(s2_r_reg) + i - HALF_WIN < int'(h_eff));
        end
        for (int k = 0; k < WIN; k++)
        begin
            cell_ctrl[k].shift   = adv && s1_valid_reg;
            cell_ctrl[k].advance = adv;
            cell_ctrl[k].row_ok  = row_ok;
            cell_ctrl[k].col_ok  = (int'(s2_c_reg) + HALF_WIN - k >= 0) &&
                                   (int'(s2_c_reg) + HALF_WIN - k < int'(w_eff));
        end
    end

    assign chain[0] = new_col;

    for (genvar k = 0; k < WIN; k++)
    begin : g_cell
        if (k < WIN - 1)
        begin : g_link
            orf_cell #(
                .DC (HALF_WIN - k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cell_ctrl[k]),
                .col_in  (chain[k]),
                .col_out (chain[k+1]),
                .partial (part[k])
            );
        end
        else
        begin : g_tail
            orf_cell #(
                .DC (HALF_WIN - k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cell_ctrl[k]),
                .col_in  (chain[k]),
                .col_out (),
                .partial (part[k])
            );
        end
    end

    // stage 3: partials registered in the cells
    logic          s3_valid_reg;
    logic [RW-1:0] s3_r_reg;
    logic [CW-1:0] s3_c_reg;
    logic          s3_last_reg;

    // stage 4: group sums
    logic               s4_valid_reg;
    logic [RW-1:0]      s4_r_reg;
    logic [CW-1:0]      s4_c_reg;
    logic               s4_last_reg;
    logic [GROUP_W-1:0] group_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_r_reg    <= s2_r_reg;
            s3_c_reg    <= s2_c_reg;
            s3_last_reg <= s2_last_reg;
            s4_r_reg    <= s3_r_reg;
            s4_c_reg    <= s3_c_reg;
            s4_last_reg <= s3_last_reg;
            for (int j = 0; j < 3; j++)
            begin
                group_reg[j] <= GROUP_W'(part[3*j]) + GROUP_W'(part[3*j+1]) +
                                GROUP_W'(part[3*j+2]);
            end
        end
    end

    // output register
    logic [SHADE_W-1:0]   total;
    logic [SHADE_W-1:0]   total_sat;
    logic [SHADE_W-1:0]   shade_reg;
    logic [ROW_OUT_W-1:0] row_out_reg;
    logic [COL_OUT_W-1:0] col_out_reg;
    logic                 last_out_reg;

    always_comb
    begin
        total     = SHADE_W'(group_reg[0]) + SHADE_W'(group_reg[1]) + SHADE_W'(group_reg[2]);
        total_sat = (total > SHADE_LIMIT) ? SHADE_LIMIT : total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            shade_reg    <= SHADE_W'(0) - total_sat;
            row_out_reg  <= ROW_OUT_W'(s4_r_reg);
            col_out_reg  <= COL_OUT_W'(s4_c_reg);
            last_out_reg <= s4_last_reg;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.shade_value = $signed(shade_reg);
    assign result_out.cell_row    = row_out_reg;
    assign result_out.cell_column = col_out_reg;
    assign result_out.frame_last  = last_out_reg;

endmodule
`default_nettype wire
